/* hw/rtl/lkvc_pkg.sv */
// Shared types for the LRU key-value cache.
// Holds the command and status structs between the controller and the datapath.
// No dependencies.
package lkvc_pkg;

	typedef struct packed {
		logic capture;
		logic scan;
		logic plan;
		logic upd;
		logic write;
		logic load_out;
	} lkvc_cmd_t;

	typedef struct packed {
		logic idx_last;
		logic is_put;
		logic hit;
		logic out_free;
	} lkvc_stat_t;

endpackage

/* hw/rtl/lkvc_ctrl.sv */
// Controller state machine of the LRU key-value cache.
// Sequences the lookup scan, the recency update, the entry write and the response.
// Depends on lkvc_pkg.
module lkvc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lkvc_pkg::lkvc_stat_t stat,
	output lkvc_pkg::lkvc_cmd_t  cmd
);
	import lkvc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SDRAIN,
		ST_DECIDE,
		ST_UPDATE,
		ST_UDRAIN,
		ST_WRITE,
		ST_RESP
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.capture  = (state_q == ST_IDLE) && in_valid;
		cmd.scan     = (state_q == ST_SCAN);
		cmd.plan     = (state_q == ST_DECIDE);
		cmd.upd      = (state_q == ST_UPDATE);
		cmd.write    = (state_q == ST_WRITE);
		cmd.load_out = (state_q == ST_RESP) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (stat.idx_last) state_q <= ST_SDRAIN;
				end
				ST_SDRAIN: state_q <= ST_DECIDE;
				ST_DECIDE: begin
					if (!stat.is_put && !stat.hit) state_q <= ST_RESP;
					else state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (stat.idx_last) state_q <= ST_UDRAIN;
				end
				ST_UDRAIN: begin
					if (stat.is_put) state_q <= ST_WRITE;
					else state_q <= ST_RESP;
				end
				ST_WRITE: state_q <= ST_IDLE;
				ST_RESP: begin
					if (stat.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/lkvc_dp.sv */
// Datapath of the LRU key-value cache: key, value and rank memories, valid bits,
// the scan accumulators, the plan registers and the output register.
// Depends on lkvc_pkg.
module lkvc_dp #(
	parameter int ENTRIES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lkvc_pkg::lkvc_cmd_t  cmd,
	output lkvc_pkg::lkvc_stat_t stat,
	input  logic [4:0]           capacity,
	input  logic                 req_type,
	input  logic signed [31:0]   key,
	input  logic signed [31:0]   value_in,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic                 found,
	output logic signed [31:0]   value_out
);
	import lkvc_pkg::*;

	localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNTW = $clog2(ENTRIES + 1);
	localparam int CMPW = (CNTW > 5) ? CNTW : 5;

	logic [31:0]   key_mem  [ENTRIES];
	logic [31:0]   val_mem  [ENTRIES];
	logic [IW-1:0] rank_mem [ENTRIES];

	logic [ENTRIES-1:0] valid_q;
	logic [CNTW-1:0]    used_q;
	logic [IW-1:0]      idx_q;

	logic        put_q;
	logic [31:0] key_q;
	logic [31:0] value_q;

	logic          scan_s1;
	logic          upd_s1;
	logic [IW-1:0] idx_s1;
	logic [31:0]   key_rd_s1;
	logic [IW-1:0] rank_rd_s1;
	logic [31:0]   val_rd_q;

	logic          hit_q;
	logic [IW-1:0] hit_idx_q;
	logic [IW-1:0] hit_rank_q;
	logic          free_q;
	logic [IW-1:0] free_idx_q;
	logic          lru_any_q;
	logic [IW-1:0] lru_idx_q;
	logic [IW-1:0] lru_rank_q;

	logic [IW-1:0] target_q;
	logic [IW-1:0] thr_q;
	logic          age_all_q;
	logic          fill_q;

	logic          out_valid_q;
	logic          found_q;
	logic [31:0]   value_out_q;

	logic [CMPW-1:0] cap_w;
	logic [CMPW-1:0] eff_cap;
	logic            room;
	logic            ent_vld;
	logic            rank_we;
	logic [IW-1:0]   rank_wd;

	always_comb begin
		cap_w = CMPW'(capacity);
		if (cap_w == '0) eff_cap = CMPW'(1);
		else if (cap_w > CMPW'(ENTRIES)) eff_cap = CMPW'(ENTRIES);
		else eff_cap = cap_w;
		room = CMPW'(used_q) < eff_cap;
	end

	assign ent_vld = valid_q[idx_s1];

	always_comb begin
		rank_we = upd_s1 && (ent_vld || idx_s1 == target_q);
		if (idx_s1 == target_q) rank_wd = '0;
		else if (age_all_q || rank_rd_s1 < thr_q) rank_wd = rank_rd_s1 + IW'(1);
		else rank_wd = rank_rd_s1;
	end

	assign stat.idx_last = (idx_q == IW'(ENTRIES - 1));
	assign stat.is_put   = put_q;
	assign stat.hit      = hit_q;
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign value_out = value_out_q;

	always_ff @(posedge clk) begin
		if (cmd.scan || cmd.upd) begin
			key_rd_s1  <= key_mem[idx_q];
			rank_rd_s1 <= rank_mem[idx_q];
		end
		idx_s1 <= idx_q;
		if (rank_we) rank_mem[idx_s1] <= rank_wd;
		if (cmd.write) begin
			key_mem[target_q] <= key_q;
			val_mem[target_q] <= value_q;
		end
		if (cmd.plan) val_rd_q <= val_mem[hit_idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			put_q   <= req_type;
			key_q   <= key;
			value_q <= value_in;
		end
		if (cmd.plan) begin
			if (hit_q) begin
				target_q  <= hit_idx_q;
				thr_q     <= hit_rank_q;
				age_all_q <= 1'b0;
				fill_q    <= 1'b0;
			end else if (room) begin
				target_q  <= free_idx_q;
				thr_q     <= '0;
				age_all_q <= 1'b1;
				fill_q    <= 1'b1;
			end else begin
				target_q  <= lru_idx_q;
				thr_q     <= lru_rank_q;
				age_all_q <= 1'b0;
				fill_q    <= 1'b0;
			end
		end
		if (cmd.capture) begin
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
			lru_any_q <= 1'b0;
		end else if (scan_s1) begin
			if (ent_vld && key_rd_s1 == key_q && !hit_q) begin
				hit_q      <= 1'b1;
				hit_idx_q  <= idx_s1;
				hit_rank_q <= rank_rd_s1;
			end
			if (!ent_vld && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_s1;
			end
			if (ent_vld && (!lru_any_q || rank_rd_s1 > lru_rank_q)) begin
				lru_any_q  <= 1'b1;
				lru_idx_q  <= idx_s1;
				lru_rank_q <= rank_rd_s1;
			end
		end
		if (cmd.load_out) begin
			found_q     <= hit_q;
			value_out_q <= hit_q ? val_rd_q : 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			used_q      <= '0;
			idx_q       <= '0;
			scan_s1     <= 1'b0;
			upd_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			scan_s1 <= cmd.scan;
			upd_s1  <= cmd.upd;
			if (cmd.capture || cmd.plan) idx_q <= '0;
			else if (cmd.scan || cmd.upd) idx_q <= idx_q + IW'(1);
			if (cmd.write && fill_q) begin
				valid_q[target_q] <= 1'b1;
				used_q            <= used_q + CNTW'(1);
			end
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

/* hw/rtl/lru_key_value_cache.sv */
// Fully associative key-value store with least-recently-used replacement.
// A get on a hit runs the lookup scan and the recency update before its result; a get on a miss skips the update.
// A put runs the scan, the update and the entry write; one request is in flight at a time, set by the
// single-port scan over the key and rank memories, one entry per cycle, done twice except for a get miss.
// Reset clears valid bits and the fill count at once and sets capacity to 16.
module lru_key_value_cache #(
	parameter int ENTRIES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [4:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic signed [31:0] key,
	input  logic signed [31:0] value_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               found,
	output logic signed [31:0] value_out
);
	import lkvc_pkg::*;

	lkvc_cmd_t  cmd;
	lkvc_stat_t stat;
	logic [4:0] capacity_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= 5'd16;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	lkvc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lkvc_dp #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.capacity  (capacity_q),
		.req_type  (req_type),
		.key       (key),
		.value_in  (value_in),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.found     (found),
		.value_out (value_out)
	);

`ifndef SYNTHESIS
	// The block is busy for the whole of an accepted request.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in flight");

	// A miss always returns zero.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> value_out == 32'sd0)
		else $error("miss returned a nonzero value");
`endif

endmodule

/* bench/tb.sv */
// Self-checking testbench for lru_key_value_cache: a random and directed stream of get and
// put requests, with capacity changes between phases, checked against a built-in LRU model.
// Depends only on the lru_key_value_cache RTL.
module tb;

	localparam int ENTRIES = 16;
	localparam int SETTLE = 2 * ENTRIES + 8;
	localparam logic REQ_GET = 1'b0;
	localparam logic REQ_PUT = 1'b1;

	typedef enum logic [1:0] {STEP_REQ, STEP_CFG, STEP_DRAIN, STEP_MODE} step_kind_t;

	typedef struct {
		step_kind_t  kind;
		logic        rtype;
		logic [31:0] k;
		logic [31:0] v;
		logic [4:0]  cap;
		int          send_pct;
		int          recv_pct;
	} stim_t;

	typedef struct packed {
		logic        found;
		logic [31:0] value;
	} lookup_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [4:0]         cfg_data = 5'd0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               req_type = REQ_GET;
	logic signed [31:0] key = 32'sd0;
	logic signed [31:0] value_in = 32'sd0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               found;
	logic signed [31:0] value_out;

	stim_t   stim_q[$];
	lookup_t lookup_replies[$];

	int req_sent_cnt = 0;
	int req_acc_cnt = 0;
	int cfg_sent_cnt = 0;
	int cfg_acc_cnt = 0;
	int send_pct = 0;
	int recv_pct = 0;
	int quiet_cycles = 0;
	logic settled = 1'b0;
	int errors = 0;

	logic [31:0] line_key[ENTRIES];
	logic [31:0] line_value[ENTRIES];
	logic        line_live[ENTRIES] = '{default: 1'b0};
	int          line_age[ENTRIES] = '{default: 0};
	int          lines_filled = 0;
	logic [4:0]  capacity_reg = 5'd16;

	lru_key_value_cache #(
		.ENTRIES(ENTRIES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.key(key),
		.value_in(value_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.value_out(value_out)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void promote(int s);
		int r;
		r = line_age[s];
		for (int i = 0; i < ENTRIES; i++) begin
			if (line_live[i] && line_age[i] < r) line_age[i]++;
		end
		line_age[s] = 0;
	endfunction

	function automatic void apply_request(logic rtype, logic [31:0] k, logic [31:0] v);
		int hit_slot;
		int free_slot;
		int victim;
		int eff_cap;
		hit_slot = -1;
		free_slot = -1;
		victim = -1;
		for (int i = 0; i < ENTRIES; i++) begin
			if (hit_slot < 0 && line_live[i] && line_key[i] == k) hit_slot = i;
		end
		if (rtype == REQ_GET) begin
			if (hit_slot >= 0) begin
				promote(hit_slot);
				lookup_replies.push_back('{1'b1, line_value[hit_slot]});
			end else begin
				lookup_replies.push_back('{1'b0, 32'd0});
			end
		end else if (hit_slot >= 0) begin
			line_value[hit_slot] = v;
			promote(hit_slot);
		end else begin
			eff_cap = (capacity_reg == 0) ? 1 : int'(capacity_reg);
			if (eff_cap > ENTRIES) eff_cap = ENTRIES;
			if (lines_filled < eff_cap) begin
				for (int i = ENTRIES - 1; i >= 0; i--) begin
					if (!line_live[i]) free_slot = i;
				end
			end
			if (free_slot >= 0) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (line_live[i]) line_age[i]++;
				end
				line_live[free_slot] = 1'b1;
				line_key[free_slot] = k;
				line_value[free_slot] = v;
				line_age[free_slot] = 0;
				lines_filled++;
			end else if (lines_filled > 0) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (line_live[i] && (victim < 0 || line_age[i] > line_age[victim])) victim = i;
				end
				promote(victim);
				line_key[victim] = k;
				line_value[victim] = v;
			end
		end
	endfunction

	function automatic void push_step(step_kind_t kind, logic rtype, logic [31:0] k,
			logic [31:0] v, logic [4:0] cap, int sp, int rp);
		stim_t s;
		s.kind = kind;
		s.rtype = rtype;
		s.k = k;
		s.v = v;
		s.cap = cap;
		s.send_pct = sp;
		s.recv_pct = rp;
		stim_q.push_back(s);
	endfunction

	function automatic void queue_req(logic rtype, logic [31:0] k, logic [31:0] v);
		push_step(STEP_REQ, rtype, k, v, 5'd0, 0, 0);
	endfunction

	function automatic void queue_chunk(int count);
		logic [31:0] pool[$];
		logic [31:0] k;
		int pool_size;
		pool_size = $urandom_range(3, 24);
		for (int i = 0; i < pool_size; i++) begin
			case ($urandom_range(7))
			0: pool.push_back(32'h8000_0000);
			1: pool.push_back(32'h7fff_ffff);
			2: pool.push_back(32'hffff_ffff);
			default: pool.push_back($urandom);
			endcase
		end
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(15) == 0) k = $urandom;
			else k = pool[$urandom_range(pool_size - 1)];
			queue_req($urandom_range(1) ? REQ_PUT : REQ_GET, k, $urandom);
		end
	endfunction

	always @(posedge clk) begin : accept_requests
		if (arst_n && in_valid && in_ready) begin
			req_acc_cnt++;
			apply_request(req_type, key, value_in);
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			cfg_acc_cnt++;
			capacity_reg = cfg_data;
		end
	end

	always @(negedge clk) begin : drive_requests
		stim_t head;
		logic req_pending;
		logic cfg_pending;
		logic next_in_valid;
		logic next_cfg_valid;
		req_pending = in_valid && (req_acc_cnt != req_sent_cnt);
		cfg_pending = cfg_valid && (cfg_acc_cnt != cfg_sent_cnt);
		next_in_valid = req_pending;
		next_cfg_valid = cfg_pending;
		if (arst_n && !req_pending && !cfg_pending) begin
			if (quiet_cycles != 0) begin
				quiet_cycles--;
			end else if (stim_q.size() != 0) begin
				head = stim_q[0];
				case (head.kind)
				STEP_MODE: begin
					send_pct = head.send_pct;
					recv_pct = head.recv_pct;
					void'(stim_q.pop_front());
				end
				STEP_REQ: begin
					if ($urandom_range(99) >= send_pct) begin
						void'(stim_q.pop_front());
						req_type <= head.rtype;
						key <= head.k;
						value_in <= head.v;
						next_in_valid = 1'b1;
						req_sent_cnt++;
					end
				end
				default: begin
					if (lookup_replies.size() == 0) begin
						if (!settled) begin
							quiet_cycles = SETTLE;
							settled = 1'b1;
						end else begin
							void'(stim_q.pop_front());
							settled = 1'b0;
							if (head.kind == STEP_CFG) begin
								cfg_data <= head.cap;
								next_cfg_valid = 1'b1;
								cfg_sent_cnt++;
							end
						end
					end
				end
				endcase
			end
		end
		in_valid <= next_in_valid;
		cfg_valid <= next_cfg_valid;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_pct);
	end

	always @(posedge clk) begin : check_lookups
		lookup_t want;
		if (arst_n && out_valid && out_ready) begin
			if (lookup_replies.size() == 0) begin
				$display("%0t: unexpected result, expected none, got found=%0b value=%0d",
					$time, found, value_out);
				errors++;
			end else begin
				want = lookup_replies.pop_front();
				if (found !== want.found) begin
					$display("%0t: found mismatch, expected %0b, got %0b",
						$time, want.found, found);
					errors++;
				end
				if (value_out !== want.value) begin
					$display("%0t: value_out mismatch, expected %0d, got %0d",
						$time, $signed(want.value), value_out);
					errors++;
				end
			end
		end
	end

	initial begin : build_stimulus
		logic [4:0] cap_plan[9];
		int send_plan[3];
		int recv_plan[3];
		cap_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd8, 5'd3, 5'd4, 5'd12};
		cap_plan[6] = 5'($urandom_range(31));
		send_plan = '{35, 79, 0};
		recv_plan = '{79, 35, 0};

		push_step(STEP_MODE, REQ_GET, 32'd0, 32'd0, 5'd0, send_plan[0], recv_plan[0]);
		queue_req(REQ_GET, 32'h0000_0000, 32'hffff_ffff);
		queue_req(REQ_GET, 32'h8000_0000, 32'h0000_0000);
		queue_req(REQ_GET, 32'h7fff_ffff, 32'h0000_0000);
		queue_req(REQ_PUT, 32'h8000_0000, 32'h7fff_ffff);
		queue_req(REQ_PUT, 32'h7fff_ffff, 32'h8000_0000);
		queue_req(REQ_PUT, 32'hffff_ffff, 32'hffff_ffff);
		queue_req(REQ_PUT, 32'h0000_0000, 32'h0000_0000);
		queue_req(REQ_GET, 32'h8000_0000, 32'h0000_0000);
		queue_req(REQ_GET, 32'h7fff_ffff, 32'h0000_0000);
		queue_req(REQ_GET, 32'hffff_ffff, 32'h0000_0000);
		queue_req(REQ_GET, 32'h0000_0000, 32'h0000_0000);
		queue_req(REQ_GET, 32'h0000_0001, 32'h0000_0000);
		queue_req(REQ_PUT, 32'h8000_0000, 32'h0000_0005);
		queue_req(REQ_GET, 32'h8000_0000, 32'h0000_0000);
		push_step(STEP_CFG, REQ_GET, 32'd0, 32'd0, 5'd2, 0, 0);
		queue_req(REQ_PUT, 32'd100, 32'd1100);
		queue_req(REQ_PUT, 32'd200, 32'd1200);
		queue_req(REQ_GET, 32'h7fff_ffff, 32'h0000_0000);
		queue_req(REQ_GET, 32'd100, 32'd0);
		queue_req(REQ_GET, 32'd200, 32'd0);
		push_step(STEP_CFG, REQ_GET, 32'd0, 32'd0, 5'd0, 0, 0);
		queue_req(REQ_PUT, 32'd300, 32'd1300);
		queue_req(REQ_GET, 32'd300, 32'd0);
		queue_req(REQ_GET, 32'd200, 32'd0);

		for (int p = 0; p < 3; p++) begin
			push_step(STEP_MODE, REQ_GET, 32'd0, 32'd0, 5'd0, send_plan[p], recv_plan[p]);
			for (int c = 0; c < 3; c++) begin
				push_step(STEP_CFG, REQ_GET, 32'd0, 32'd0, cap_plan[p * 3 + c], 0, 0);
				queue_chunk(58);
				if (p == 2 && c == 1) push_step(STEP_DRAIN, REQ_GET, 32'd0, 32'd0, 5'd0, 0, 0);
				queue_chunk(59);
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (stim_q.size() != 0 || in_valid || cfg_valid || lookup_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0 && lookup_replies.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/lkvc_pkg.sv
hw/rtl/lkvc_ctrl.sv
hw/rtl/lkvc_dp.sv
hw/rtl/lru_key_value_cache.sv
bench/tb.sv
